[hw/rtl/chained_hash_accumulate_table_defines.svh]
// Assertion macros used by the hash table top level.
`ifndef CHAINED_HASH_ACCUMULATE_TABLE_DEFINES_SVH
`define CHAINED_HASH_ACCUMULATE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CHAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CHAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/chat_pkg.sv]
// Types, constants and codes shared by the hash table modules.
`default_nettype none
package chat_pkg;

  localparam int DEF_BUCKETS    = 256;
  localparam int DEF_POOL_NODES = 256;
  localparam int DEF_KEY_PARTS  = 4;

  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF0000;

  localparam logic [2:0] KEY_LENGTH_RESET = 3'd4;
  localparam logic [0:0] KEY_LENGTH_ADDR  = 1'b0;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_HEAD_TAKE,
    ST_CHECK,
    ST_NODE_CMP,
    ST_INSERT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_HASH,
    CMD_MOD,
    CMD_HEAD_RD,
    CMD_HEAD_TAKE,
    CMD_NODE_RD,
    CMD_ADVANCE,
    CMD_HIT,
    CMD_MISS,
    CMD_FULL,
    CMD_POP_RD,
    CMD_INSERT
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hash_last;
    logic mod_done;
    logic node_null;
    logic walk_over;
    logic key_match;
    logic pool_full;
    logic is_insert;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/chained_hash_accumulate_table.sv]
// Top level: chained hash table with accumulate-on-insert, APB key length register.
// out_valid rises once the key parts are hashed, reduced to a bucket (a long division when
// BUCKETS is not a power of two) and the chain is walked node by node.
// One transaction at a time.
// After reset a clearing pass over the bucket heads and free stack runs with busy high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
`default_nettype none
`include "chained_hash_accumulate_table_defines.svh"
module chained_hash_accumulate_table #(
  parameter int BUCKETS    = chat_pkg::DEF_BUCKETS,
  parameter int POOL_NODES = chat_pkg::DEF_POOL_NODES,
  parameter int KEY_PARTS  = chat_pkg::DEF_KEY_PARTS,
  localparam int CW        = $clog2(POOL_NODES + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_grid_index_0,
  input  logic signed [31:0] in_grid_index_1,
  input  logic signed [31:0] in_grid_index_2,
  input  logic signed [31:0] in_particle_index,
  input  logic signed [31:0] in_add_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_result_value,
  output logic [CW-1:0]      out_entry_count
);
  import chat_pkg::*;

  logic [2:0]  key_length_r;
  dp_cmd_t     cmd;
  dp_status_t  st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr == KEY_LENGTH_ADDR) begin
      key_length_r <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == KEY_LENGTH_ADDR) ? {29'd0, key_length_r} : 32'd0;

  chat_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  chat_dp #(
    .BUCKETS    (BUCKETS),
    .POOL_NODES (POOL_NODES),
    .KEY_PARTS  (KEY_PARTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .key_length        (key_length_r),
    .in_mode           (in_mode),
    .in_grid_index_0   (in_grid_index_0),
    .in_grid_index_1   (in_grid_index_1),
    .in_grid_index_2   (in_grid_index_2),
    .in_particle_index (in_particle_index),
    .in_add_value      (in_add_value),
    .st                (st),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_result_value  (out_result_value),
    .out_entry_count   (out_entry_count)
  );

  `CHAT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `CHAT_ASSERT_NXT(a_strobe_single, out_valid, !out_valid, "result strobe longer than one cycle")
  `CHAT_ASSERT_IMP(a_strobe_idle, out_valid, !busy, "result strobed while still busy")
  `CHAT_ASSERT_IMP(a_count_range, out_valid, out_entry_count <= CW'(POOL_NODES), "count over pool")

endmodule
`default_nettype wire

[hw/rtl/chat_ctrl.sv]
// Controller state machine sequencing clearing pass, hash, bucket reduction, chain walk and update.
`default_nettype none
module chat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  chat_pkg::dp_status_t st,
  output chat_pkg::dp_cmd_t   cmd,
  output logic                busy
);
  import chat_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (st.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd = CMD_HASH;
        if (st.hash_last) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (st.mod_done) begin
          cmd       = CMD_HEAD_RD;
          state_nxt = ST_HEAD_TAKE;
        end else begin
          cmd = CMD_MOD;
        end
      end
      ST_HEAD_TAKE: begin
        cmd       = CMD_HEAD_TAKE;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // End of chain or walk limit reached: the key is absent.
        if (st.node_null || st.walk_over) begin
          if (st.is_insert && !st.pool_full) begin
            cmd       = CMD_POP_RD;
            state_nxt = ST_INSERT;
          end else if (st.is_insert) begin
            cmd       = CMD_FULL;
            state_nxt = ST_IDLE;
          end else begin
            cmd       = CMD_MISS;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd       = CMD_NODE_RD;
          state_nxt = ST_NODE_CMP;
        end
      end
      ST_NODE_CMP: begin
        if (st.key_match) begin
          cmd       = CMD_HIT;
          state_nxt = ST_IDLE;
        end else begin
          cmd       = CMD_ADVANCE;
          state_nxt = ST_CHECK;
        end
      end
      ST_INSERT: begin
        cmd       = CMD_INSERT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

[hw/rtl/chat_dp.sv]
// Datapath: key registers, hash, bucket reduction, node memories and free stack.
`default_nettype none
module chat_dp #(
  parameter int BUCKETS    = chat_pkg::DEF_BUCKETS,
  parameter int POOL_NODES = chat_pkg::DEF_POOL_NODES,
  parameter int KEY_PARTS  = chat_pkg::DEF_KEY_PARTS,
  localparam int CW        = $clog2(POOL_NODES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  chat_pkg::dp_cmd_t    cmd,
  input  logic [2:0]           key_length,
  input  logic [1:0]           in_mode,
  input  logic signed [31:0]   in_grid_index_0,
  input  logic signed [31:0]   in_grid_index_1,
  input  logic signed [31:0]   in_grid_index_2,
  input  logic signed [31:0]   in_particle_index,
  input  logic signed [31:0]   in_add_value,
  output chat_pkg::dp_status_t st,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic signed [31:0]   out_result_value,
  output logic [CW-1:0]        out_entry_count
);
  import chat_pkg::*;

  localparam int BW   = $clog2(BUCKETS);
  localparam int IW   = $clog2(POOL_NODES);
  localparam int LW   = CW;
  localparam int KW   = KEY_PARTS * 32;
  localparam int MAXD = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
  localparam int CLW  = $clog2(MAXD + 1);
  localparam int PW   = $clog2(KEY_PARTS);
  localparam bit IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_NODES);

  logic [LW-1:0] head_mem  [BUCKETS];
  logic [KW-1:0] key_mem   [POOL_NODES];
  logic [31:0]   sum_mem   [POOL_NODES];
  logic [LW-1:0] link_mem  [POOL_NODES];
  logic [IW-1:0] stack_mem [POOL_NODES];

  logic [LW-1:0]  head_q, link_q;
  logic [KW-1:0]  key_q;
  logic [31:0]    sum_q;
  logic [IW-1:0]  stack_q;

  logic [1:0]     mode_r;
  logic [31:0]    k_r [KEY_PARTS];
  logic [31:0]    add_r;
  logic [2:0]     len_r;
  logic [63:0]    h_r;
  logic [PW-1:0]  part_r;
  logic [LW-1:0]  node_r, prev_r, steps_r, head_r, used_r;
  logic [CLW-1:0] clr_cnt_r;
  logic           out_valid_r;
  logic [1:0]     out_status_r;
  logic [31:0]    out_value_r;

  logic [2:0]     len_eff;
  logic [31:0]    grid [4];
  logic [31:0]    k_load [KEY_PARTS];
  logic [KW-1:0]  k_flat;
  logic [31:0]    kp;
  logic [63:0]    h_nxt;
  logic [BW-1:0]  bkt;
  logic           mod_done;
  logic           match;
  logic [32:0]    sum_wide;
  logic [31:0]    sat_sum;
  logic [IW-1:0]  pop_addr, push_addr, node_idx, prev_idx;
  logic           is_del, prev_null;

  assign grid[0] = in_grid_index_0;
  assign grid[1] = in_grid_index_1;
  assign grid[2] = in_grid_index_2;
  assign grid[3] = 32'd0;

  always_comb begin
    if (key_length == 3'd0) begin
      len_eff = 3'd1;
    end else if (key_length > 3'(KEY_PARTS)) begin
      len_eff = 3'(KEY_PARTS);
    end else begin
      len_eff = key_length;
    end
  end

  // Parts beyond the key length are stored as zero.
  always_comb begin
    for (int i = 0; i < KEY_PARTS; i++) begin
      if (3'(i) == len_eff - 3'd1) begin
        k_load[i] = in_particle_index;
      end else if (3'(i) < len_eff - 3'd1) begin
        k_load[i] = grid[i];
      end else begin
        k_load[i] = 32'd0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_PARTS; i++) begin
      k_flat[i*32 +: 32] = k_r[i];
    end
  end

  assign kp    = k_r[part_r];
  assign h_nxt = (h_r << HASH_SHIFT) + h_r + {{32{kp[31]}}, kp};

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < KEY_PARTS; i++) begin
      if (3'(i) < len_r && key_q[i*32 +: 32] != k_r[i]) match = 1'b0;
    end
  end

  assign sum_wide = {sum_q[31], sum_q} + {add_r[31], add_r};
  assign sat_sum  = (sum_wide[32] != sum_wide[31]) ?
                    (sum_wide[32] ? 32'h80000000 : 32'h7FFFFFFF) : sum_wide[31:0];

  assign pop_addr  = IW'(LW'(POOL_NODES - 1) - used_r);
  assign push_addr = IW'(LW'(POOL_NODES) - used_r);
  assign node_idx  = node_r[IW-1:0];
  assign prev_idx  = prev_r[IW-1:0];
  assign is_del    = (mode_r == MODE_DELETE);
  assign prev_null = (prev_r >= NULL_LINK);

  generate
    if (IS_POW2) begin : g_pow2
      assign bkt      = h_r[BW-1:0];
      assign mod_done = 1'b1;
    end else begin : g_div
      // Reduction one hash byte at a time, most significant byte first: a reciprocal
      // estimate of the quotient falls short by at most two, fixed by compare and subtract.
      localparam logic [9:0] RECIP = 10'((64'd1 << (BW + 9)) / 64'(BUCKETS));
      logic [BW-1:0] rem_r;
      logic [BW+1:0] prem_r;
      logic [4:0]    mcnt_r;
      logic [2:0]    dig;
      logic [7:0]    digit;
      logic [BW+7:0] t;
      logic [18:0]   qprod;
      logic [BW+8:0] qb;
      logic [BW+1:0] rem0;
      logic [BW+1:0] rem1;

      assign dig   = mcnt_r[3:1];
      assign digit = h_r[{3'd7 - dig, 3'b000} +: 8];
      assign t     = {rem_r, digit};
      assign qprod = 19'(t[BW+7:BW-1]) * 19'(RECIP);
      assign qb    = (BW+9)'(qprod[18:10]) * (BW+9)'(BUCKETS);
      assign rem0  = (BW+2)'({1'b0, t} - qb);
      assign rem1  = (prem_r >= (BW+2)'(2 * BUCKETS)) ? prem_r - (BW+2)'(2 * BUCKETS) :
                     (prem_r >= (BW+2)'(BUCKETS)) ? prem_r - (BW+2)'(BUCKETS) : prem_r;

      always_ff @(posedge clk) begin
        if (cmd == CMD_LOAD) begin
          rem_r  <= '0;
          mcnt_r <= 5'd0;
        end else if (cmd == CMD_MOD) begin
          mcnt_r <= mcnt_r + 5'd1;
          if (!mcnt_r[0]) begin
            prem_r <= rem0;
          end else begin
            rem_r <= rem1[BW-1:0];
          end
        end
      end

      assign bkt      = rem_r;
      assign mod_done = (mcnt_r == 5'd16);
    end
  endgenerate

  // Bucket heads.
  always_ff @(posedge clk) begin
    if (cmd == CMD_CLEAR && clr_cnt_r < CLW'(BUCKETS)) begin
      head_mem[clr_cnt_r[BW-1:0]] <= NULL_LINK;
    end else if (cmd == CMD_INSERT) begin
      head_mem[bkt] <= LW'(stack_q);
    end else if (cmd == CMD_HIT && is_del && prev_null) begin
      head_mem[bkt] <= link_q;
    end
    if (cmd == CMD_HEAD_RD) head_q <= head_mem[bkt];
  end

  // Node key, sum and link memories.
  always_ff @(posedge clk) begin
    if (cmd == CMD_INSERT) begin
      key_mem[stack_q] <= k_flat;
    end
    if (cmd == CMD_NODE_RD) key_q <= key_mem[node_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_INSERT) begin
      sum_mem[stack_q] <= add_r;
    end else if (cmd == CMD_HIT && mode_r == MODE_INSERT) begin
      sum_mem[node_idx] <= sat_sum;
    end
    if (cmd == CMD_NODE_RD) sum_q <= sum_mem[node_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_INSERT) begin
      link_mem[stack_q] <= head_r;
    end else if (cmd == CMD_HIT && is_del && !prev_null) begin
      link_mem[prev_idx] <= link_q;
    end
    if (cmd == CMD_NODE_RD) link_q <= link_mem[node_idx];
  end

  // Free-node stack; after the clearing pass entry j holds POOL_NODES-1-j.
  always_ff @(posedge clk) begin
    if (cmd == CMD_CLEAR && clr_cnt_r < CLW'(POOL_NODES)) begin
      stack_mem[clr_cnt_r[IW-1:0]] <= IW'(POOL_NODES - 1) - clr_cnt_r[IW-1:0];
    end else if (cmd == CMD_HIT && is_del && used_r != '0) begin
      stack_mem[push_addr] <= node_idx;
    end
    if (cmd == CMD_POP_RD) stack_q <= stack_mem[pop_addr];
  end

  // Operation registers.
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        mode_r <= in_mode;
        k_r    <= k_load;
        add_r  <= in_add_value;
        len_r  <= len_eff;
        h_r    <= HASH_SEED;
        part_r <= '0;
      end
      CMD_HASH: begin
        h_r    <= h_nxt;
        part_r <= part_r + PW'(1);
      end
      CMD_HEAD_TAKE: begin
        node_r  <= head_q;
        head_r  <= head_q;
        prev_r  <= NULL_LINK;
        steps_r <= '0;
      end
      CMD_ADVANCE: begin
        prev_r  <= node_r;
        node_r  <= link_q;
        steps_r <= steps_r + LW'(1);
      end
      CMD_HIT: begin
        out_status_r <= STATUS_OK;
        out_value_r  <= (mode_r == MODE_INSERT) ? sat_sum : sum_q;
      end
      CMD_MISS: begin
        out_status_r <= STATUS_NOT_FOUND;
        out_value_r  <= MISS_VALUE;
      end
      CMD_FULL: begin
        out_status_r <= STATUS_POOL_FULL;
        out_value_r  <= MISS_VALUE;
      end
      CMD_INSERT: begin
        out_status_r <= STATUS_OK;
        out_value_r  <= add_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd == CMD_HIT) || (cmd == CMD_MISS) ||
                     (cmd == CMD_FULL) || (cmd == CMD_INSERT);
      if (cmd == CMD_CLEAR) clr_cnt_r <= clr_cnt_r + CLW'(1);
      if (cmd == CMD_INSERT) begin
        used_r <= used_r + LW'(1);
      end else if (cmd == CMD_HIT && is_del && used_r != '0) begin
        used_r <= used_r - LW'(1);
      end
    end
  end

  always_comb begin
    st.clear_last = (clr_cnt_r == CLW'(MAXD - 1));
    st.hash_last  = ((3'(part_r) + 3'd1) == len_r);
    st.mod_done   = mod_done;
    st.node_null  = (node_r >= NULL_LINK);
    st.walk_over  = (steps_r >= LW'(POOL_NODES));
    st.key_match  = match;
    st.pool_full  = (used_r >= LW'(POOL_NODES));
    st.is_insert  = (mode_r == MODE_INSERT);
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_entry_count  = used_r;

endmodule
`default_nettype wire
